FILE: hw/rtl/fgn_pkg.sv
// Shared types, constants and tables of the fractal gradient noise block.
`timescale 1ns / 1ps

package fgn_pkg;

  localparam int MAX_OCTAVES_DEF = 8;
  localparam int HASH_SIZE       = 256;

  // Field and internal widths
  localparam int COORD_W = 32;
  localparam int FREQ_W  = 32;
  localparam int OCT_CFG_W = 4;
  localparam int LAC_W   = 16;
  localparam int PERS_W  = 16;
  localparam int NOISE_W = 16;
  localparam int AMP_W   = 17;
  localparam int RANGE_W = 21;
  localparam int SUM_W   = 40;
  localparam int DIVS_W  = RANGE_W + 1;
  localparam int VAL_W   = 20;
  localparam int FC_W    = 22;
  localparam int FADE_W  = 17;
  localparam int MUL_W   = 34;
  localparam int PROD_W  = 2 * MUL_W;

  // Configuration register indexes
  localparam logic [1:0] REG_BASE_FREQ = 2'd0;
  localparam logic [1:0] REG_OCTAVES   = 2'd1;
  localparam logic [1:0] REG_LACUN     = 2'd2;
  localparam logic [1:0] REG_PERSIST   = 2'd3;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  // Datapath operations
  localparam logic [3:0] OP_COORD  = 4'd0;
  localparam logic [3:0] OP_FADE_A = 4'd1;
  localparam logic [3:0] OP_FADE_B = 4'd2;
  localparam logic [3:0] OP_FADE_L = 4'd3;
  localparam logic [3:0] OP_HASH_A = 4'd4;
  localparam logic [3:0] OP_HASH_B = 4'd5;
  localparam logic [3:0] OP_HASH_C = 4'd6;
  localparam logic [3:0] OP_DOT    = 4'd7;
  localparam logic [3:0] OP_LERP   = 4'd8;
  localparam logic [3:0] OP_ACC    = 4'd9;
  localparam logic [3:0] OP_FREQ   = 4'd10;
  localparam logic [3:0] OP_AMP    = 4'd11;

  localparam logic [4:0] LAST_STEP = 5'd28;

  typedef struct packed {
    logic       load;
    logic       wb;
    logic [3:0] op;
    logic [2:0] arg;
    logic       div_start;
    logic       out_load;
  } cmd_t;

  typedef struct packed {
    logic [3:0] op;
    logic [2:0] arg;
  } step_t;

  // Per-octave program: one entry per step
  function automatic step_t step_decode(input logic [4:0] step);
    step_t s;
    s.op  = OP_COORD;
    s.arg = 3'd0;
    case (step)
      5'd0, 5'd1, 5'd2: begin
        s.op = OP_COORD; s.arg = step[2:0];
      end
      5'd3, 5'd7, 5'd11: begin
        s.op = OP_FADE_A; s.arg = 3'((step - 5'd3) >> 2);
      end
      5'd4, 5'd5, 5'd8, 5'd9, 5'd12, 5'd13: begin
        s.op = OP_FADE_B; s.arg = 3'((step - 5'd3) >> 2);
      end
      5'd6, 5'd10, 5'd14: begin
        s.op = OP_FADE_L; s.arg = 3'((step - 5'd3) >> 2);
      end
      5'd15: s.op = OP_HASH_A;
      5'd16: s.op = OP_HASH_B;
      5'd17: s.op = OP_HASH_C;
      5'd18: s.op = OP_DOT;
      5'd19, 5'd20, 5'd21, 5'd22, 5'd23, 5'd24, 5'd25: begin
        s.op = OP_LERP; s.arg = 3'(step - 5'd19);
      end
      5'd26: s.op = OP_ACC;
      5'd27: s.op = OP_FREQ;
      5'd28: s.op = OP_AMP;
      default: s.op = OP_COORD;
    endcase
    return s;
  endfunction

  // Gradient component masks, bit i for gradient i
  localparam logic [15:0] GX_POS = 16'h1055;
  localparam logic [15:0] GX_NEG = 16'h20AA;
  localparam logic [15:0] GY_POS = 16'h3503;
  localparam logic [15:0] GY_NEG = 16'hCA0C;
  localparam logic [15:0] GZ_POS = 16'h4330;
  localparam logic [15:0] GZ_NEG = 16'h8CC0;

  localparam logic [7:0] PERM_TAB [0:HASH_SIZE-1] = '{
    8'd151,8'd160,8'd137,8'd91,8'd90,8'd15,8'd131,8'd13,
    8'd201,8'd95,8'd96,8'd53,8'd194,8'd233,8'd7,8'd225,
    8'd140,8'd36,8'd103,8'd30,8'd69,8'd142,8'd8,8'd99,
    8'd37,8'd240,8'd21,8'd10,8'd23,8'd190,8'd6,8'd148,
    8'd247,8'd120,8'd234,8'd75,8'd0,8'd26,8'd197,8'd62,
    8'd94,8'd252,8'd219,8'd203,8'd117,8'd35,8'd11,8'd32,
    8'd57,8'd177,8'd33,8'd88,8'd237,8'd149,8'd56,8'd87,
    8'd174,8'd20,8'd125,8'd136,8'd171,8'd168,8'd68,8'd175,
    8'd74,8'd165,8'd71,8'd134,8'd139,8'd48,8'd27,8'd166,
    8'd77,8'd146,8'd158,8'd231,8'd83,8'd111,8'd229,8'd122,
    8'd60,8'd211,8'd133,8'd230,8'd220,8'd105,8'd92,8'd41,
    8'd55,8'd46,8'd245,8'd40,8'd244,8'd102,8'd143,8'd54,
    8'd65,8'd25,8'd63,8'd161,8'd1,8'd216,8'd80,8'd73,
    8'd209,8'd76,8'd132,8'd187,8'd208,8'd89,8'd18,8'd169,
    8'd200,8'd196,8'd135,8'd130,8'd116,8'd188,8'd159,8'd86,
    8'd164,8'd100,8'd109,8'd198,8'd173,8'd186,8'd3,8'd64,
    8'd52,8'd217,8'd226,8'd250,8'd124,8'd123,8'd5,8'd202,
    8'd38,8'd147,8'd118,8'd126,8'd255,8'd82,8'd85,8'd212,
    8'd207,8'd206,8'd59,8'd227,8'd47,8'd16,8'd58,8'd17,
    8'd182,8'd189,8'd28,8'd42,8'd223,8'd183,8'd170,8'd213,
    8'd119,8'd248,8'd152,8'd2,8'd44,8'd154,8'd163,8'd70,
    8'd221,8'd153,8'd101,8'd155,8'd167,8'd43,8'd172,8'd9,
    8'd129,8'd22,8'd39,8'd253,8'd19,8'd98,8'd108,8'd110,
    8'd79,8'd113,8'd224,8'd232,8'd178,8'd185,8'd112,8'd104,
    8'd218,8'd246,8'd97,8'd228,8'd251,8'd34,8'd242,8'd193,
    8'd238,8'd210,8'd144,8'd12,8'd191,8'd179,8'd162,8'd241,
    8'd81,8'd51,8'd145,8'd235,8'd249,8'd14,8'd239,8'd107,
    8'd49,8'd192,8'd214,8'd31,8'd181,8'd199,8'd106,8'd157,
    8'd184,8'd84,8'd204,8'd176,8'd115,8'd121,8'd50,8'd45,
    8'd127,8'd4,8'd150,8'd254,8'd138,8'd236,8'd205,8'd93,
    8'd222,8'd114,8'd67,8'd29,8'd24,8'd72,8'd243,8'd141,
    8'd128,8'd195,8'd78,8'd66,8'd215,8'd61,8'd156,8'd180
  };

endpackage

FILE: hw/rtl/fgn_div.sv
// Restoring divider, one quotient bit per cycle, unsigned operands.
`timescale 1ns / 1ps

module fgn_div (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [fgn_pkg::SUM_W-1:0]  dividend,
  input  logic [fgn_pkg::DIVS_W-1:0] divisor,
  output logic                      done,
  output logic [fgn_pkg::SUM_W-1:0]  quotient
);
  import fgn_pkg::*;

  localparam int CNT_W = $clog2(SUM_W + 1);

  logic [SUM_W-1:0]  quo_r;
  logic [DIVS_W-1:0] rem_r;
  logic [DIVS_W-1:0] dvs_r;
  logic [CNT_W-1:0]  cnt_r;
  logic              busy_r;
  logic              done_r;
  logic [DIVS_W:0]   trial;
  logic              fits;

  assign trial = {rem_r, quo_r[SUM_W-1]};
  assign fits  = trial >= {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(SUM_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (busy_r) begin
      rem_r <= fits ? DIVS_W'(trial - {1'b0, dvs_r}) : DIVS_W'(trial);
      quo_r <= {quo_r[SUM_W-2:0], fits};
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

FILE: hw/rtl/fgn_dp.sv
// Noise datapath: operand registers, shared multiplier, hashing and final scaling.
`timescale 1ns / 1ps

module fgn_dp (
  input  logic                         clk,
  input  logic                         rst_n,
  input  fgn_pkg::cmd_t                cmd,
  input  logic [3*fgn_pkg::COORD_W-1:0] in_data,
  input  logic [fgn_pkg::FREQ_W-1:0]   base_freq,
  input  logic [fgn_pkg::LAC_W-1:0]    lacunarity,
  input  logic [fgn_pkg::PERS_W-1:0]   persistence,
  output logic                         div_done,
  output logic [fgn_pkg::NOISE_W-1:0]  noise
);
  import fgn_pkg::*;

  logic signed [COORD_W-1:0] c_r [3];
  logic [FREQ_W-1:0]  freq_r;
  logic [AMP_W-1:0]   amp_r;
  logic [RANGE_W-1:0] range_r;
  logic signed [SUM_W-1:0] sum_r;
  logic [7:0]  cell_r [3];
  logic [15:0] t_r [3];
  logic signed [FC_W-1:0] fc_r [3];
  logic [FADE_W-1:0] f_r [3];
  logic [7:0]  ha_r [2];
  logic [7:0]  hb_r [4];
  logic [3:0]  g_r [8];
  logic signed [VAL_W-1:0] v_r [8];
  logic signed [PROD_W-1:0] prod_r;
  logic neg_r;
  logic [NOISE_W-1:0] noise_r;

  logic signed [MUL_W-1:0] ma, mb;
  logic [1:0] k;
  logic [1:0] fsel;
  logic signed [VAL_W-1:0] va, vb;
  logic signed [MUL_W-1:0] t34;
  logic signed [FC_W-1:0] pq;
  logic [SUM_W-1:0] quo;
  logic [SUM_W-1:0] mag;

  assign k   = cmd.arg[1:0];
  assign t34 = $signed({18'b0, t_r[k]});
  assign pq  = $signed(prod_r[FC_W+15:16]);

  function automatic logic signed [VAL_W-1:0] dot(input logic [3:0] g,
                                                  input logic [2:0] idx,
                                                  input logic [15:0] tx,
                                                  input logic [15:0] ty,
                                                  input logic [15:0] tz);
    logic signed [VAL_W-1:0] dx, dy, dz, acc;
    dx  = idx[0] ? $signed({4'b0, tx}) - 20'sd65536 : $signed({4'b0, tx});
    dy  = idx[1] ? $signed({4'b0, ty}) - 20'sd65536 : $signed({4'b0, ty});
    dz  = idx[2] ? $signed({4'b0, tz}) - 20'sd65536 : $signed({4'b0, tz});
    acc = '0;
    if (GX_POS[g]) acc = acc + dx;
    if (GX_NEG[g]) acc = acc - dx;
    if (GY_POS[g]) acc = acc + dy;
    if (GY_NEG[g]) acc = acc - dy;
    if (GZ_POS[g]) acc = acc + dz;
    if (GZ_NEG[g]) acc = acc - dz;
    return acc;
  endfunction

  // Lerp operand pairs for the three blend levels
  always_comb begin
    va   = v_r[0];
    vb   = v_r[1];
    fsel = 2'd0;
    case (cmd.arg)
      3'd0: begin va = v_r[0]; vb = v_r[1]; fsel = 2'd0; end
      3'd1: begin va = v_r[2]; vb = v_r[3]; fsel = 2'd0; end
      3'd2: begin va = v_r[4]; vb = v_r[5]; fsel = 2'd0; end
      3'd3: begin va = v_r[6]; vb = v_r[7]; fsel = 2'd0; end
      3'd4: begin va = v_r[0]; vb = v_r[2]; fsel = 2'd1; end
      3'd5: begin va = v_r[4]; vb = v_r[6]; fsel = 2'd1; end
      3'd6: begin va = v_r[0]; vb = v_r[4]; fsel = 2'd2; end
      default: begin va = v_r[0]; vb = v_r[0]; fsel = 2'd0; end
    endcase
  end

  // Multiplier operand select
  always_comb begin
    ma = '0;
    mb = '0;
    case (cmd.op)
      OP_COORD: begin
        ma = MUL_W'(c_r[k]);
        mb = $signed({2'b0, freq_r});
      end
      OP_FADE_A: begin
        ma = t34;
        mb = (t34 <<< 2) + (t34 <<< 1) - 34'sd983040;
      end
      OP_FADE_B, OP_FADE_L: begin
        ma = MUL_W'(fc_r[k]);
        mb = t34;
      end
      OP_LERP: begin
        ma = MUL_W'(vb) - MUL_W'(va);
        mb = $signed({17'b0, f_r[fsel]});
      end
      OP_ACC: begin
        ma = MUL_W'(v_r[0]);
        mb = $signed({17'b0, amp_r});
      end
      OP_FREQ: begin
        ma = $signed({2'b0, freq_r});
        mb = $signed({18'b0, lacunarity});
      end
      OP_AMP: begin
        ma = $signed({17'b0, amp_r});
        mb = $signed({18'b0, persistence});
      end
      default: begin
        ma = '0;
        mb = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      c_r[0]  <= $signed(in_data[COORD_W-1:0]);
      c_r[1]  <= $signed(in_data[2*COORD_W-1:COORD_W]);
      c_r[2]  <= $signed(in_data[3*COORD_W-1:2*COORD_W]);
      freq_r  <= base_freq;
      amp_r   <= AMP_W'(65536);
      range_r <= '0;
      sum_r   <= '0;
    end else if (!cmd.wb) begin
      prod_r <= ma * mb;
    end else begin
      case (cmd.op)
        OP_COORD: begin
          cell_r[k] <= prod_r[47:40];
          t_r[k]    <= prod_r[39:24];
        end
        OP_FADE_A: fc_r[k] <= pq + 22'sd655360;
        OP_FADE_B: fc_r[k] <= pq;
        OP_FADE_L: begin
          if (pq < 0) f_r[k] <= '0;
          else if (pq > 22'sd65536) f_r[k] <= FADE_W'(65536);
          else f_r[k] <= pq[FADE_W-1:0];
        end
        OP_HASH_A: begin
          ha_r[0] <= PERM_TAB[cell_r[0]];
          ha_r[1] <= PERM_TAB[8'(cell_r[0] + 8'd1)];
        end
        OP_HASH_B: begin
          for (int j = 0; j < 4; j++) begin
            hb_r[j] <= PERM_TAB[8'(ha_r[j%2] + cell_r[1] + 8'(j/2))];
          end
        end
        OP_HASH_C: begin
          for (int i = 0; i < 8; i++) begin
            g_r[i] <= PERM_TAB[8'(hb_r[i%4] + cell_r[2] + 8'(i/4))][3:0];
          end
        end
        OP_DOT: begin
          for (int i = 0; i < 8; i++) begin
            v_r[i] <= dot(g_r[i], 3'(i), t_r[0], t_r[1], t_r[2]);
          end
        end
        OP_LERP: begin
          case (cmd.arg)
            3'd0: v_r[0] <= va + $signed(prod_r[VAL_W+15:16]);
            3'd1: v_r[2] <= va + $signed(prod_r[VAL_W+15:16]);
            3'd2: v_r[4] <= va + $signed(prod_r[VAL_W+15:16]);
            3'd3: v_r[6] <= va + $signed(prod_r[VAL_W+15:16]);
            3'd4: v_r[0] <= va + $signed(prod_r[VAL_W+15:16]);
            3'd5: v_r[4] <= va + $signed(prod_r[VAL_W+15:16]);
            3'd6: v_r[0] <= va + $signed(prod_r[VAL_W+15:16]);
            default: v_r[0] <= v_r[0];
          endcase
        end
        OP_ACC: begin
          sum_r   <= sum_r + $signed(prod_r[SUM_W-1:0]);
          range_r <= range_r + RANGE_W'(amp_r);
        end
        OP_FREQ: begin
          if (prod_r[47:40] != 8'd0) freq_r <= '1;
          else freq_r <= prod_r[39:8];
        end
        OP_AMP: amp_r <= prod_r[32:16];
        default: amp_r <= amp_r;
      endcase
    end
  end

  // Magnitude into the divider, sign held aside
  assign mag = sum_r[SUM_W-1] ? SUM_W'(-sum_r) : SUM_W'(sum_r);

  always_ff @(posedge clk) begin
    if (cmd.div_start) neg_r <= sum_r[SUM_W-1];
  end

  fgn_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (mag),
    .divisor  ({range_r, 1'b0}),
    .done     (div_done),
    .quotient (quo)
  );

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      if (!neg_r) begin
        noise_r <= (quo > SUM_W'(32767)) ? 16'h7FFF : quo[NOISE_W-1:0];
      end else begin
        noise_r <= (quo > SUM_W'(32768)) ? 16'h8000 : NOISE_W'(-quo[NOISE_W-1:0]);
      end
    end
  end

  assign noise = noise_r;

endmodule

FILE: hw/rtl/fgn_ctrl.sv
// Sequencer: steps the per-octave program, runs the divider, drives the handshakes.
`timescale 1ns / 1ps

module fgn_ctrl #(
  parameter int MAX_OCTAVES = fgn_pkg::MAX_OCTAVES_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  input  logic [fgn_pkg::OCT_CFG_W-1:0] octave_count,
  input  logic                          div_done,
  output fgn_pkg::cmd_t                 cmd
);
  import fgn_pkg::*;

  localparam int OCT_W = $clog2(MAX_OCTAVES + 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RUN  = 3'd1;
  localparam logic [2:0] S_DIV  = 3'd2;
  localparam logic [2:0] S_DIVW = 3'd3;
  localparam logic [2:0] S_FIN  = 3'd4;

  logic [2:0] state_r, state_nxt;
  logic [4:0] step_r, step_nxt;
  logic       phase_r, phase_nxt;
  logic [OCT_W-1:0] oct_r, oct_nxt;
  logic       valid_r, valid_nxt;
  logic [4:0] n_oct;
  logic [OCT_W-1:0] last_oct;
  step_t      st;
  logic       slot_free;

  always_comb begin
    if (octave_count == '0) n_oct = 5'd1;
    else if ({1'b0, octave_count} > 5'(MAX_OCTAVES)) n_oct = 5'(MAX_OCTAVES);
    else n_oct = {1'b0, octave_count};
  end
  assign last_oct  = OCT_W'(n_oct - 5'd1);
  assign st        = step_decode(step_r);
  assign slot_free = !valid_r || out_tready;

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    phase_nxt = phase_r;
    oct_nxt   = oct_r;
    valid_nxt = valid_r;
    cmd.load      = 1'b0;
    cmd.wb        = phase_r;
    cmd.op        = st.op;
    cmd.arg       = st.arg;
    cmd.div_start = 1'b0;
    cmd.out_load  = 1'b0;
    in_tready     = 1'b0;
    if (valid_r && out_tready) valid_nxt = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        cmd.wb    = 1'b0;
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          step_nxt  = '0;
          phase_nxt = 1'b0;
          oct_nxt   = '0;
          state_nxt = S_RUN;
        end
      end
      S_RUN: begin
        phase_nxt = !phase_r;
        if (phase_r) begin
          if (step_r == LAST_STEP) begin
            step_nxt = '0;
            oct_nxt  = oct_r + 1'b1;
            if (oct_r == last_oct) state_nxt = S_DIV;
          end else begin
            step_nxt = step_r + 5'd1;
          end
        end
      end
      S_DIV: begin
        cmd.wb        = 1'b0;
        cmd.div_start = 1'b1;
        state_nxt     = S_DIVW;
      end
      S_DIVW: begin
        cmd.wb = 1'b0;
        if (div_done) state_nxt = S_FIN;
      end
      S_FIN: begin
        cmd.wb = 1'b0;
        if (slot_free) begin
          cmd.out_load = 1'b1;
          valid_nxt    = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      step_r  <= '0;
      phase_r <= 1'b0;
      oct_r   <= '0;
      valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
      phase_r <= phase_nxt;
      oct_r   <= oct_nxt;
      valid_r <= valid_nxt;
    end
  end

  assign out_tvalid = valid_r;

endmodule

FILE: hw/rtl/fractal_gradient_noise_3d.sv
// Top level of the fractal 3D gradient noise block: configuration registers and wiring.
`timescale 1ns / 1ps

// Usage
//   in_*  : one item per 3D point, coordinates in signed Q16.16.
//   out_* : one item per point, noise_value in signed Q1.15, saturated.
//   cfg_* : write-only registers: 0 base frequency, 1 octave count,
//           2 lacunarity, 3 persistence; unknown indexes are dropped.
//           Write them only while no point is in flight.
// Operation
//   One point at a time. Each octave runs a fixed 29-step program through
//   one shared multiplier, each step a multiply phase and then a write-back.
//   The final normalization goes through a bit-serial divider. The next point
//   is accepted in the cycle after the result loads, and in_tready is high
//   only between points.
// Reset
//   rst_n (synchronous, active low) loads the register defaults and drops
//   any point in flight; no result is pending after reset.
// Back-pressure
//   The result sits in an output register; a new point is accepted while
//   it waits, and the next result holds until out_tready takes the old one.

module fractal_gradient_noise_3d #(
  parameter int MAX_OCTAVES = fgn_pkg::MAX_OCTAVES_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // coord_x [31:0], coord_y [63:32], coord_z [95:64]
  input  logic [3*fgn_pkg::COORD_W-1:0]     in_tdata,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // noise_value [15:0]
  output logic [fgn_pkg::NOISE_W-1:0]       out_tdata,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  input  logic                              cfg_we,
  input  logic [fgn_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [fgn_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import fgn_pkg::*;

  logic [FREQ_W-1:0]    base_freq_r;
  logic [OCT_CFG_W-1:0] octaves_r;
  logic [LAC_W-1:0]     lacun_r;
  logic [PERS_W-1:0]    persist_r;
  cmd_t                 cmd;
  logic                 div_done;

  // Hold configuration; writes land on the clock edge with cfg_we high
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_freq_r <= FREQ_W'(559241);
      octaves_r   <= OCT_CFG_W'(4);
      lacun_r     <= LAC_W'(512);
      persist_r   <= PERS_W'(32768);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_BASE_FREQ: base_freq_r <= cfg_data[FREQ_W-1:0];
        REG_OCTAVES:   octaves_r   <= cfg_data[OCT_CFG_W-1:0];
        REG_LACUN:     lacun_r     <= cfg_data[LAC_W-1:0];
        REG_PERSIST:   persist_r   <= cfg_data[PERS_W-1:0];
        default:       octaves_r   <= octaves_r;
      endcase
    end
  end

  fgn_ctrl #(
    .MAX_OCTAVES (MAX_OCTAVES)
  ) u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_tvalid    (in_tvalid),
    .in_tready    (in_tready),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .octave_count (octaves_r),
    .div_done     (div_done),
    .cmd          (cmd)
  );

  fgn_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .in_data     (in_tdata),
    .base_freq   (base_freq_r),
    .lacunarity  (lacun_r),
    .persistence (persist_r),
    .div_done    (div_done),
    .noise       (out_tdata)
  );

endmodule
